// ----- hw/rtl/ciw_pkg.sv -----
package ciw_pkg;

    // field widths
    localparam int POS_W      = 24;
    localparam int VAL_W      = 18;
    localparam int ERR_W      = 17;
    localparam int R9_W       = 17;
    localparam int SHIFT_W    = 12;
    localparam int PIDX_W     = 4;
    localparam int TSEL_W     = 2;
    localparam int MODE_W     = 2;
    localparam int PTS_W      = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 5;

    // stream payload layout
    localparam int S_TDATA_W = 120;
    localparam int M_TDATA_W = 24;
    localparam int TSEL_LSB  = 0;
    localparam int PIDX_LSB  = 2;
    localparam int POS_LSB   = 6;
    localparam int VAL_LSB   = 30;
    localparam int EUP_LSB   = 48;
    localparam int EDN_LSB   = 65;
    localparam int BAR_LSB   = 82;
    localparam int R9_LSB    = 83;
    localparam int PID_LSB   = 100;
    localparam int SHF_LSB   = 101;

    // breakpoint entry layout in the table memory
    localparam int ENTRY_W   = POS_W + VAL_W + 2 * ERR_W;
    localparam int E_POS_LSB = 0;
    localparam int E_VAL_LSB = E_POS_LSB + POS_W;
    localparam int E_EUP_LSB = E_VAL_LSB + VAL_W;
    localparam int E_EDN_LSB = E_EUP_LSB + ERR_W;

    // datapath widths
    localparam int SH_W   = SHIFT_W + 1;
    localparam int DIFF_W = VAL_W + 1;
    localparam int MULB_W = POS_W + 1;
    localparam int PROD_W = DIFF_W + MULB_W;
    localparam int NUM_W  = PROD_W + 2;
    localparam int DEN_W  = POS_W + 1;
    localparam int QW     = 20;
    localparam int QCNT_W = 5;
    localparam int QS_W   = QW + 2;
    localparam int T_W    = 33;
    localparam int RQ_W   = T_W - 8;

    // constants
    localparam logic [R9_W-1:0]         R9_CUT  = 17'd61604;
    localparam logic signed [VAL_W-1:0] ONE_Q14 = 18'sd16384;
    localparam logic signed [VAL_W-1:0] W_MAX   = 18'sh1ffff;
    localparam logic signed [VAL_W-1:0] W_MIN   = 18'sh20000;

    // item kinds
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // category modes
    localparam logic [MODE_W-1:0] MODE_TABLES  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_UNKNOWN = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REQ_ID  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_R9_CORR = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PTS0    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PTS1    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PTS2    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PTS3    = 3'd6;

    typedef struct packed {
        logic                    start;
        logic signed [NUM_W-1:0] num;
        logic [DEN_W-1:0]        den;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic signed [QW:0]   quot;
    } t_div_rsp;

endpackage

// ----- hw/rtl/ciw_ram.sv -----
module ciw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/ciw_div.sv -----
module ciw_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ciw_pkg::t_div_req i_req,
    output ciw_pkg::t_div_rsp o_rsp
);

    logic                          r_busy;
    logic                          r_done;
    logic [ciw_pkg::QCNT_W-1:0]    r_cnt;
    logic                          r_neg;
    logic [ciw_pkg::NUM_W-1:0]     r_rem;
    logic [ciw_pkg::NUM_W-1:0]     r_dsh;
    logic [ciw_pkg::QW-1:0]        r_q;

    logic                          n_neg;
    logic [ciw_pkg::NUM_W-1:0]     den_ext;
    logic [ciw_pkg::NUM_W-1:0]     n_mag;
    logic                          ge;
    logic [ciw_pkg::QW:0]          q_ext;

    // floor for negative numerators: -floor((|n| + d - 1) / d)
    always_comb begin
        n_neg   = i_req.num[ciw_pkg::NUM_W-1];
        den_ext = {{(ciw_pkg::NUM_W - ciw_pkg::DEN_W){1'b0}}, i_req.den};
        if (n_neg) begin
            n_mag = den_ext - 1'b1 - i_req.num;
        end else begin
            n_mag = i_req.num;
        end
        ge    = r_rem >= r_dsh;
        q_ext = {1'b0, r_q};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == ciw_pkg::QCNT_W'(ciw_pkg::QW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // restoring division, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_neg <= n_neg;
            r_rem <= n_mag;
            r_dsh <= den_ext << (ciw_pkg::QW - 1);
            r_q   <= '0;
        end else if (r_busy) begin
            if (ge) begin
                r_rem <= r_rem - r_dsh;
            end
            r_q   <= {r_q[ciw_pkg::QW-2:0], ge};
            r_dsh <= r_dsh >> 1;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_neg ? -$signed(q_ext) : $signed(q_ext);

endmodule

// ----- hw/rtl/category_interpolated_weight.sv -----
// per-category piecewise linear weight lookup. a load item (tuser 0) writes one breakpoint
// (position, value, upper and lower error) into one of four category tables and returns
// weight 0, accepted 1. a query item (tuser 1) picks the table from barrel/endcap and
// r9 >= 0.94, scans the breakpoints one per cycle out of the table memory until the first
// one not below the momentum, then interpolates value and error through one shared
// iterative divider (one quotient bit a cycle) and one shared multiplier. a query that
// lands on an end point skips the value and error divisions, and the scan never reads
// past the table's point count. queries that need no table (unknown categorization, id
// gate, region-only mode) finish like loads. the input side is ready only while idle;
// one finished result can wait in the output register while the next item is accepted.
// configuration is written through a plain write port and must only change while idle.
module category_interpolated_weight #(
    parameter int MAX_POINTS = 16,
    parameter int NUM_TABLES = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // slave stream
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // table_select, point_index, position, value, error_up, error_down,
    // in_barrel, shower_r9, passes_id, shift_amount
    input  logic [ciw_pkg::S_TDATA_W-1:0]     i_s_axis_tdata,
    // kind
    input  logic                              i_s_axis_tuser,
    // master stream
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // weight_out
    output logic [ciw_pkg::M_TDATA_W-1:0]     o_m_axis_tdata,
    // accepted
    output logic                              o_m_axis_tuser,
    // configuration write port
    input  logic                              i_cfg_we,
    input  logic [ciw_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ciw_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int DEPTH  = NUM_TABLES * MAX_POINTS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int IDX_W  = $clog2(MAX_POINTS);

    // one-hot sequencer
    typedef enum logic [11:0] {
        S_IDLE  = 12'b000000000001,
        S_FETCH = 12'b000000000010,
        S_SCAN  = 12'b000000000100,
        S_MUL_V = 12'b000000001000,
        S_DST_V = 12'b000000010000,
        S_DWT_V = 12'b000000100000,
        S_MUL_E = 12'b000001000000,
        S_DST_E = 12'b000010000000,
        S_DWT_E = 12'b000100000000,
        S_MUL_F = 12'b001000000000,
        S_FIN   = 12'b010000000000,
        S_DONE  = 12'b100000000000
    } t_state;

    t_state r_state;
    t_state n_state;

    // configuration registers
    logic [ciw_pkg::MODE_W-1:0] r_mode;
    logic                       r_req_id;
    logic                       r_r9_corr;
    logic [ciw_pkg::PTS_W-1:0]  r_pts [NUM_TABLES];

    // input field unpack
    logic                               in_kind;
    logic [ciw_pkg::TSEL_W-1:0]         in_tsel;
    logic [ciw_pkg::PIDX_W-1:0]         in_pidx;
    logic [ciw_pkg::POS_W-1:0]          in_pos;
    logic signed [ciw_pkg::VAL_W-1:0]   in_val;
    logic [ciw_pkg::ERR_W-1:0]          in_eup;
    logic [ciw_pkg::ERR_W-1:0]          in_edn;
    logic                               in_barrel;
    logic [ciw_pkg::R9_W-1:0]           in_r9;
    logic                               in_pid;
    logic signed [ciw_pkg::SHIFT_W-1:0] in_shift;

    assign in_kind   = i_s_axis_tuser;
    assign in_tsel   = i_s_axis_tdata[ciw_pkg::TSEL_LSB +: ciw_pkg::TSEL_W];
    assign in_pidx   = i_s_axis_tdata[ciw_pkg::PIDX_LSB +: ciw_pkg::PIDX_W];
    assign in_pos    = i_s_axis_tdata[ciw_pkg::POS_LSB +: ciw_pkg::POS_W];
    assign in_val    = i_s_axis_tdata[ciw_pkg::VAL_LSB +: ciw_pkg::VAL_W];
    assign in_eup    = i_s_axis_tdata[ciw_pkg::EUP_LSB +: ciw_pkg::ERR_W];
    assign in_edn    = i_s_axis_tdata[ciw_pkg::EDN_LSB +: ciw_pkg::ERR_W];
    assign in_barrel = i_s_axis_tdata[ciw_pkg::BAR_LSB];
    assign in_r9     = i_s_axis_tdata[ciw_pkg::R9_LSB +: ciw_pkg::R9_W];
    assign in_pid    = i_s_axis_tdata[ciw_pkg::PID_LSB];
    assign in_shift  = i_s_axis_tdata[ciw_pkg::SHF_LSB +: ciw_pkg::SHIFT_W];

    logic s_xfer;
    logic out_free;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign s_xfer          = i_s_axis_tvalid && o_s_axis_tready;

    // item payload and working registers
    logic [ciw_pkg::POS_W-1:0]          r_pt;
    logic signed [ciw_pkg::SH_W-1:0]    r_shift;
    logic                               r_up;
    logic [ciw_pkg::TSEL_W-1:0]         r_table;
    logic [IDX_W-1:0]                   r_idx;
    logic [IDX_W-1:0]                   r_last;
    logic [ciw_pkg::POS_W-1:0]          r_prev_pos;
    logic signed [ciw_pkg::VAL_W-1:0]   r_prev_val;
    logic [ciw_pkg::ERR_W-1:0]          r_prev_err;
    logic signed [ciw_pkg::DIFF_W-1:0]  r_a;
    logic signed [ciw_pkg::DIFF_W-1:0]  r_b;
    logic signed [ciw_pkg::DIFF_W-1:0]  r_ea;
    logic signed [ciw_pkg::DIFF_W-1:0]  r_eb;
    logic [ciw_pkg::POS_W-1:0]          r_num;
    logic [ciw_pkg::POS_W-1:0]          r_den;
    logic signed [ciw_pkg::PROD_W-1:0]  r_prod;
    logic signed [ciw_pkg::DIFF_W-1:0]  r_y;
    logic signed [ciw_pkg::DIFF_W-1:0]  r_e;
    logic signed [ciw_pkg::VAL_W-1:0]   r_res;
    logic                               r_res_acc;

    // output register
    logic                               r_m_valid;
    logic [ciw_pkg::VAL_W-1:0]          r_m_data;
    logic                               r_m_acc;

    // accept-time decode: category, effective shift, point count
    logic                               in_is_load;
    logic                               in_r9_high;
    logic signed [ciw_pkg::SH_W-1:0]    in_shift_ext;
    logic signed [ciw_pkg::SH_W-1:0]    acc_shift;
    logic                               acc_up;
    logic [ciw_pkg::TSEL_W-1:0]         acc_table;
    logic [ciw_pkg::PTS_W-1:0]          acc_pts;
    logic [IDX_W-1:0]                   acc_last;
    logic                               acc_unknown;
    logic                               acc_update;
    logic                               acc_lookup;

    always_comb begin
        in_is_load   = (in_kind == ciw_pkg::KIND_LOAD);
        in_r9_high   = (in_r9 >= ciw_pkg::R9_CUT);
        in_shift_ext = {in_shift[ciw_pkg::SHIFT_W-1], in_shift};
        // r9 correlation flips the shift sign for low r9
        if (r_r9_corr && !in_r9_high) begin
            acc_shift = -in_shift_ext;
        end else begin
            acc_shift = in_shift_ext;
        end
        acc_up    = !acc_shift[ciw_pkg::SH_W-1] && (acc_shift != '0);
        acc_table = {!in_barrel, !in_r9_high};
        acc_pts   = r_pts[acc_table];
        // count of zero acts as one, counts beyond the table are clamped
        if (acc_pts == '0) begin
            acc_last = '0;
        end else if (int'(acc_pts) > MAX_POINTS) begin
            acc_last = IDX_W'(MAX_POINTS - 1);
        end else begin
            acc_last = IDX_W'(acc_pts - 1'b1);
        end
        acc_unknown = (r_mode >= ciw_pkg::MODE_UNKNOWN);
        acc_update  = r_r9_corr || !r_req_id || in_pid;
        acc_lookup  = (in_kind == ciw_pkg::KIND_QUERY) && !acc_unknown && acc_update
                      && (r_mode == ciw_pkg::MODE_TABLES);
    end

    // breakpoint table memory, one entry per table slot
    logic                          ram_we;
    logic [ADDR_W-1:0]             ram_waddr;
    logic [ciw_pkg::ENTRY_W-1:0]   ram_wdata;
    logic [ADDR_W-1:0]             ram_raddr;
    logic [ciw_pkg::ENTRY_W-1:0]   ram_rdata;
    logic [IDX_W-1:0]              rd_idx;

    // slots beyond the table size are dropped
    assign ram_we    = s_xfer && in_is_load && (int'(in_pidx) < MAX_POINTS);
    assign ram_waddr = ADDR_W'(int'(in_tsel) * MAX_POINTS + int'(in_pidx));
    assign ram_wdata = {in_edn, in_eup, in_val, in_pos};
    // prefetch the next breakpoint while the current one is compared
    assign rd_idx    = (r_state == S_SCAN && r_idx != r_last) ? IDX_W'(r_idx + 1'b1) : r_idx;
    assign ram_raddr = ADDR_W'(int'(r_table) * MAX_POINTS + int'(rd_idx));

    ciw_ram #(
        .WIDTH (ciw_pkg::ENTRY_W),
        .DEPTH (DEPTH)
    ) u_tables (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    logic [ciw_pkg::POS_W-1:0]        rd_pos;
    logic signed [ciw_pkg::VAL_W-1:0] rd_val;
    logic [ciw_pkg::ERR_W-1:0]        rd_err;
    logic                             rd_below;

    always_comb begin
        rd_pos   = ram_rdata[ciw_pkg::E_POS_LSB +: ciw_pkg::POS_W];
        rd_val   = ram_rdata[ciw_pkg::E_VAL_LSB +: ciw_pkg::VAL_W];
        rd_err   = r_up ? ram_rdata[ciw_pkg::E_EUP_LSB +: ciw_pkg::ERR_W]
                        : ram_rdata[ciw_pkg::E_EDN_LSB +: ciw_pkg::ERR_W];
        rd_below = (r_pt > rd_pos);
    end

    // shared multiplier: slope numerators, then error times shift
    logic signed [ciw_pkg::DIFF_W-1:0] mul_a;
    logic signed [ciw_pkg::MULB_W-1:0] mul_b;
    logic signed [ciw_pkg::PROD_W-1:0] mul_p;

    always_comb begin
        case (r_state)
            S_MUL_V: begin
                mul_a = r_b - r_a;
                mul_b = {1'b0, r_num};
            end
            S_MUL_E: begin
                mul_a = r_eb - r_ea;
                mul_b = {1'b0, r_num};
            end
            default: begin
                mul_a = r_e;
                mul_b = {{(ciw_pkg::MULB_W - ciw_pkg::SH_W){r_shift[ciw_pkg::SH_W-1]}}, r_shift};
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    // shared divider: floor((2 * diff * num + den) / (2 * den))
    ciw_pkg::t_div_req div_req;
    ciw_pkg::t_div_rsp div_rsp;

    always_comb begin
        div_req.start = (r_state == S_DST_V) || (r_state == S_DST_E);
        div_req.num   = {r_prod[ciw_pkg::PROD_W-1], r_prod, 1'b0}
                        + {{(ciw_pkg::NUM_W - ciw_pkg::POS_W){1'b0}}, r_den};
        div_req.den   = {r_den, 1'b0};
    end

    ciw_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // interpolated point = low end + rounded quotient
    logic signed [ciw_pkg::DIFF_W-1:0] blend_base;
    logic [ciw_pkg::QS_W-1:0]          blend_sum;

    always_comb begin
        blend_base = (r_state == S_DWT_V) ? r_a : r_ea;
        blend_sum  = {{(ciw_pkg::QS_W - ciw_pkg::DIFF_W){blend_base[ciw_pkg::DIFF_W-1]}},
                      blend_base}
                     + {{(ciw_pkg::QS_W - ciw_pkg::QW - 1){div_rsp.quot[ciw_pkg::QW]}},
                        div_rsp.quot};
    end

    // final value * 256 + error * shift, round half up, saturate
    logic [ciw_pkg::T_W-1:0]           fin_t;
    logic [ciw_pkg::T_W-1:0]           fin_tr;
    logic [ciw_pkg::RQ_W-1:0]          fin_rq;
    logic                              sat_hi;
    logic                              sat_lo;
    logic signed [ciw_pkg::VAL_W-1:0]  fin_res;

    always_comb begin
        fin_t  = {{(ciw_pkg::T_W - ciw_pkg::DIFF_W - 8){r_y[ciw_pkg::DIFF_W-1]}}, r_y, 8'b0}
                 + r_prod[ciw_pkg::T_W-1:0];
        fin_tr = fin_t + ciw_pkg::T_W'(128);
        fin_rq = fin_tr[ciw_pkg::T_W-1:8];
        sat_hi = !fin_rq[ciw_pkg::RQ_W-1]
                 && (fin_rq[ciw_pkg::RQ_W-2:ciw_pkg::VAL_W-1] != '0);
        sat_lo = fin_rq[ciw_pkg::RQ_W-1]
                 && (fin_rq[ciw_pkg::RQ_W-2:ciw_pkg::VAL_W-1] != '1);
        if (sat_hi) begin
            fin_res = ciw_pkg::W_MAX;
        end else if (sat_lo) begin
            fin_res = ciw_pkg::W_MIN;
        end else begin
            fin_res = fin_rq[ciw_pkg::VAL_W-1:0];
        end
    end

    assign out_free = !r_m_valid || i_m_axis_tready;

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (s_xfer) begin
                    n_state = acc_lookup ? S_FETCH : S_DONE;
                end
            end
            S_FETCH: n_state = S_SCAN;
            S_SCAN: begin
                if (rd_below && r_idx != r_last) begin
                    n_state = S_SCAN;
                end else if (rd_below || r_idx == '0) begin
                    n_state = S_MUL_F;
                end else begin
                    n_state = S_MUL_V;
                end
            end
            S_MUL_V: n_state = S_DST_V;
            S_DST_V: n_state = S_DWT_V;
            S_DWT_V: begin
                if (div_rsp.done) begin
                    n_state = S_MUL_E;
                end
            end
            S_MUL_E: n_state = S_DST_E;
            S_DST_E: n_state = S_DWT_E;
            S_DWT_E: begin
                if (div_rsp.done) begin
                    n_state = S_MUL_F;
                end
            end
            S_MUL_F: n_state = S_FIN;
            S_FIN:   n_state = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_m_valid <= 1'b0;
            r_mode    <= '0;
            r_req_id  <= 1'b0;
            r_r9_corr <= 1'b0;
            for (int t = 0; t < NUM_TABLES; t++) begin
                r_pts[t] <= ciw_pkg::PTS_W'(1);
            end
        end else begin
            r_state <= n_state;
            if (r_state == S_DONE && out_free) begin
                r_m_valid <= 1'b1;
            end else if (r_m_valid && i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    ciw_pkg::CFG_MODE:    r_mode    <= i_cfg_data[ciw_pkg::MODE_W-1:0];
                    ciw_pkg::CFG_REQ_ID:  r_req_id  <= i_cfg_data[0];
                    ciw_pkg::CFG_R9_CORR: r_r9_corr <= i_cfg_data[0];
                    ciw_pkg::CFG_PTS0:    r_pts[0]  <= i_cfg_data;
                    ciw_pkg::CFG_PTS1:    r_pts[1]  <= i_cfg_data;
                    ciw_pkg::CFG_PTS2:    r_pts[2]  <= i_cfg_data;
                    ciw_pkg::CFG_PTS3:    r_pts[3]  <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (s_xfer) begin
                    r_pt    <= in_pos;
                    r_shift <= acc_shift;
                    r_up    <= acc_up;
                    r_table <= acc_table;
                    r_last  <= acc_last;
                    r_idx   <= '0;
                    // the table path overwrites this in the final step
                    if (in_is_load) begin
                        r_res     <= '0;
                        r_res_acc <= 1'b1;
                    end else if (acc_unknown) begin
                        r_res     <= in_val;
                        r_res_acc <= 1'b0;
                    end else if (!acc_update) begin
                        r_res     <= in_val;
                        r_res_acc <= 1'b1;
                    end else begin
                        r_res     <= ciw_pkg::ONE_Q14;
                        r_res_acc <= 1'b1;
                    end
                end
            end
            S_SCAN: begin
                if (rd_below && r_idx != r_last) begin
                    r_idx      <= IDX_W'(r_idx + 1'b1);
                    r_prev_pos <= rd_pos;
                    r_prev_val <= rd_val;
                    r_prev_err <= rd_err;
                end else if (rd_below || r_idx == '0) begin
                    // momentum outside the table: clamp to this end point
                    r_y <= {rd_val[ciw_pkg::VAL_W-1], rd_val};
                    r_e <= {2'b00, rd_err};
                end else begin
                    r_a   <= {r_prev_val[ciw_pkg::VAL_W-1], r_prev_val};
                    r_b   <= {rd_val[ciw_pkg::VAL_W-1], rd_val};
                    r_ea  <= {2'b00, r_prev_err};
                    r_eb  <= {2'b00, rd_err};
                    r_num <= r_pt - r_prev_pos;
                    r_den <= rd_pos - r_prev_pos;
                end
            end
            S_MUL_V, S_MUL_E, S_MUL_F: begin
                r_prod <= mul_p;
            end
            S_DWT_V: begin
                if (div_rsp.done) begin
                    r_y <= blend_sum[ciw_pkg::DIFF_W-1:0];
                end
            end
            S_DWT_E: begin
                if (div_rsp.done) begin
                    r_e <= blend_sum[ciw_pkg::DIFF_W-1:0];
                end
            end
            S_FIN: begin
                r_res     <= fin_res;
                r_res_acc <= 1'b1;
            end
            S_DONE: begin
                if (out_free) begin
                    r_m_data <= r_res;
                    r_m_acc  <= r_res_acc;
                end
            end
            default: ;
        endcase
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = {{(ciw_pkg::M_TDATA_W - ciw_pkg::VAL_W){1'b0}}, r_m_data};
    assign o_m_axis_tuser  = r_m_acc;

`ifndef SYNTHESIS
    // the scan never runs past the last breakpoint in use
    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_idx <= r_last))
        else $error("breakpoint scan beyond point count");

    // divider results only arrive while the sequencer waits for them
    a_div_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_DWT_V || r_state == S_DWT_E))
        else $error("divider done outside a wait state");

    // a taken result is not replaced unless a new one is being delivered
    a_out_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && i_m_axis_tready && r_state != S_DONE) |=> !o_m_axis_tvalid)
        else $error("result repeated after transfer");
`endif

endmodule
